FILE: hw/rtl/ssset_pkg.sv
// ssset_pkg: shared constants, codes and types of the scanline span set
// no dependencies; imported by ssset_eval, the top module and the checker
`default_nettype none

package ssset_pkg;

    localparam int LINES     = 256;
    localparam int MAX_SPANS = 16;
    localparam int PIXELS    = 1024;

    localparam int LINE_W    = $clog2(LINES);
    localparam int SPAN_W    = $clog2(MAX_SPANS);
    localparam int CNT_W     = $clog2(MAX_SPANS + 1);
    localparam int PX_W      = $clog2(PIXELS);
    localparam int ADDR_W    = LINE_W + SPAN_W;

    localparam int XW        = 12;   // x_start, x_end
    localparam int LW        = 11;   // line
    localparam int MINLINE_W = 8;    // line window registers
    localparam int CFG_W     = 10;   // widest register
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_LINE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LINE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PX   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PX   = 2'd3;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_DEL = 2'd1,
        KIND_QRY = 2'd2,
        KIND_CLR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_IGNORED = 2'd1,
        STAT_FULL    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MODE_ADD  = 2'd0,
        MODE_DEL  = 2'd1,
        MODE_QRY  = 2'd2,
        MODE_INFO = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLIP,
        ST_CNT_RD,
        ST_CNT_WT,
        ST_FETCH,
        ST_EVAL,
        ST_FINISH,
        ST_WB,
        ST_CNT_WR,
        ST_INFO_RD,
        ST_INFO_WT,
        ST_RESP
    } state_t;

    // one decision of the span evaluator
    typedef struct packed {
        logic            emit;
        logic            adv;
        logic [PX_W-1:0] emit_s;
        logic [PX_W-1:0] emit_e;
        logic            merged_next;
        logic            pend_next;
        logic [PX_W-1:0] acc_s_next;
        logic [PX_W-1:0] acc_e_next;
        logic            hit;
    } step_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ssset_ram.sv
// ssset_ram: simple dual-port memory, one write and one registered read port
// no dependencies
`default_nettype none

module ssset_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ssset_eval.sv
// ssset_eval: per-span decision for add, delete and query walks
// depends on ssset_pkg
`default_nettype none

module ssset_eval
    import ssset_pkg::*;
(
    input  wire mode_t                  mode,
    input  wire logic [PX_W-1:0]        span_s,
    input  wire logic [PX_W-1:0]        span_e,
    input  wire logic [PX_W-1:0]        x1,
    input  wire logic [PX_W-1:0]        x2,
    input  wire logic signed [XW-1:0]   q_px,
    input  wire logic [PX_W-1:0]        acc_s,
    input  wire logic [PX_W-1:0]        acc_e,
    input  wire logic                   merged,
    input  wire logic                   pend,
    output step_t                       step
);

    logic [PX_W:0]        e_p1;
    logic [PX_W:0]        x2_p1;
    logic signed [XW-1:0] s_sx;
    logic signed [XW-1:0] e_sx;

    assign e_p1  = {1'b0, span_e} + (PX_W+1)'(1);
    assign x2_p1 = {1'b0, x2} + (PX_W+1)'(1);
    assign s_sx  = $signed({{(XW-PX_W){1'b0}}, span_s});
    assign e_sx  = $signed({{(XW-PX_W){1'b0}}, span_e});

    always_comb begin
        step             = '0;
        step.merged_next = merged;
        step.pend_next   = pend;
        step.acc_s_next  = acc_s;
        step.acc_e_next  = acc_e;
        unique case (mode)
            MODE_ADD: begin
                if (merged) begin
                    step.emit   = 1'b1;
                    step.emit_s = span_s;
                    step.emit_e = span_e;
                    step.adv    = 1'b1;
                end else if (e_p1 < {1'b0, x1}) begin
                    step.emit   = 1'b1;
                    step.emit_s = span_s;
                    step.emit_e = span_e;
                    step.adv    = 1'b1;
                end else if ({1'b0, span_s} <= x2_p1) begin
                    // overlapping or touching: widen the accumulated span
                    step.acc_s_next = (span_s < acc_s) ? span_s : acc_s;
                    step.acc_e_next = (span_e > acc_e) ? span_e : acc_e;
                    step.adv        = 1'b1;
                end else begin
                    // first span past the union: put the union out first
                    step.emit        = 1'b1;
                    step.emit_s      = acc_s;
                    step.emit_e      = acc_e;
                    step.merged_next = 1'b1;
                end
            end
            MODE_DEL: begin
                if (span_e < x1 || span_s > x2) begin
                    step.emit   = 1'b1;
                    step.emit_s = span_s;
                    step.emit_e = span_e;
                    step.adv    = 1'b1;
                end else if (span_s < x1 && !pend) begin
                    step.emit   = 1'b1;
                    step.emit_s = span_s;
                    step.emit_e = x1 - PX_W'(1);
                    if (span_e > x2) begin
                        step.pend_next = 1'b1;   // right piece on next cycle
                    end else begin
                        step.adv = 1'b1;
                    end
                end else if (span_e > x2) begin
                    step.emit      = 1'b1;
                    step.emit_s    = x2_p1[PX_W-1:0];
                    step.emit_e    = span_e;
                    step.pend_next = 1'b0;
                    step.adv       = 1'b1;
                end else begin
                    step.adv = 1'b1;
                end
            end
            MODE_QRY: begin
                step.hit = (s_sx <= q_px) && (q_px <= e_sx);
                step.adv = 1'b1;
            end
            default: begin
                step.adv = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/scanline_span_set_top.sv
// scanline_span_set_top: per-scanline span set with add, delete, query, clear
// depends on ssset_pkg, ssset_ram, ssset_eval
//
// usage
//   s_* channel takes one command word: tuser holds the kind, tdata the
//   interval, line and align flag. m_* returns one result word per command:
//   tuser holds the status, tdata the hit flag and the line summary.
//   cfg_* writes the line and pixel window registers; the user must write
//   them only while idle, the block itself does not enforce it.
// sequence
//   one command at a time; s_tready is high only while the sequencer idles.
//   a command is clipped and the line count is read; each stored span is
//   fetched and evaluated, for an add or delete the new spans and count are
//   written back, and the line summary is read before the result word is
//   registered; a clear goes straight to the result. the sequencer returns
//   to idle before the next command is taken. the single read port of the
//   span memories and the shared evaluator set the pace of the walk.
// reset
//   aresetn low empties every line (line valid flags cleared) and loads the
//   default windows; span memories keep their contents, unreachable
// stalls
//   a finished result waits in the output register; the next command is
//   already taken and is worked on, then holds until the word is taken
`default_nettype none

module scanline_span_set_top
    import ssset_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // command words
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [39:0]          s_tdata,   // x_start, x_end, line, align, zero pad
    input  wire logic [1:0]           s_tuser,   // kind
    // result words
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [31:0]          m_tdata,   // hit, span total, first px, last px, pad
    output logic      [1:0]           m_tuser,   // status
    // window register writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    // window registers
    logic [MINLINE_W-1:0] first_line_reg, last_line_reg;
    logic [PX_W-1:0]      min_px_reg, max_px_reg;

    state_t state_reg, state_next;

    // latched command
    kind_t                kind_reg;
    logic signed [XW-1:0] xs_reg, xe_reg;
    logic signed [LW-1:0] line_reg;
    logic                 align_reg;

    // walk state
    mode_t                mode_reg;
    logic                 line_ok_reg;
    logic [PX_W-1:0]      x1_reg, x2_reg, acc_s_reg, acc_e_reg;
    logic [CNT_W-1:0]     n_reg, i_reg, k_reg, j_reg;
    logic                 merged_reg, pend_reg, hit_reg;
    status_t              status_reg;
    logic [PX_W-1:0]      left_reg, right_reg;
    logic [LINES-1:0]     valid_reg;
    logic [PX_W-1:0]      obuf_s [MAX_SPANS];
    logic [PX_W-1:0]      obuf_e [MAX_SPANS];

    logic                 m_tvalid_reg;
    logic [31:0]          m_tdata_reg;
    logic [1:0]           m_tuser_reg;

    // ---------------------------------------------------------------
    // interval preparation: swap, align, clip
    // ---------------------------------------------------------------
    logic signed [XW-1:0] lo, hi, lo_a, hi_a;
    logic signed [XW:0]   lo_x, hi_x, mnp, mxp, pmax, lo_c, hi_c, hi_t;
    logic                 clip_empty, line_ok, win_ok;
    logic [LINE_W-1:0]    lidx;

    assign lo   = (xe_reg < xs_reg) ? xe_reg : xs_reg;
    assign hi   = (xe_reg < xs_reg) ? xs_reg : xe_reg;
    assign lo_a = align_reg ? {lo[XW-1:2], 2'b00} : lo;
    assign hi_a = align_reg ? {hi[XW-1:2], 2'b11} : hi;
    assign lo_x = {lo_a[XW-1], lo_a};
    assign hi_x = {hi_a[XW-1], hi_a};
    assign mnp  = $signed({{(XW+1-PX_W){1'b0}}, min_px_reg});
    assign mxp  = $signed({{(XW+1-PX_W){1'b0}}, max_px_reg});
    assign pmax = (XW+1)'(PIXELS - 1);
    assign lo_c = (lo_x < mnp) ? mnp : lo_x;
    assign hi_t = (hi_x > mxp) ? mxp : hi_x;
    assign hi_c = (hi_t > pmax) ? pmax : hi_t;
    assign clip_empty = lo_c > hi_c;

    assign line_ok = !line_reg[LW-1] && ({1'b0, line_reg[LW-2:0]} < LW'(LINES));
    assign win_ok  = (line_reg[LW-2:0] >= (LW-1)'(first_line_reg))
                  && (line_reg[LW-2:0] <= (LW-1)'(last_line_reg));
    assign lidx    = line_reg[LINE_W-1:0];

    // ---------------------------------------------------------------
    // memories
    // ---------------------------------------------------------------
    logic               sp_re, sp_we, cnt_re, cnt_we;
    logic [ADDR_W-1:0]  sp_waddr, st_raddr, en_raddr;
    logic [PX_W-1:0]    st_rdata, en_rdata;
    logic [CNT_W-1:0]   cnt_rdata, n_eff, n_m1;
    logic               info_zero;

    assign n_m1      = n_reg - CNT_W'(1);
    assign n_eff     = valid_reg[lidx] ? cnt_rdata : '0;
    assign info_zero = !line_ok_reg || (n_reg == '0);

    ssset_ram #(.WIDTH(PX_W), .DEPTH(LINES * MAX_SPANS)) u_start_ram (
        .aclk    (aclk),
        .wr_en   (sp_we),
        .wr_addr (sp_waddr),
        .wr_data (obuf_s[j_reg[SPAN_W-1:0]]),
        .rd_en   (sp_re),
        .rd_addr (st_raddr),
        .rd_data (st_rdata)
    );

    ssset_ram #(.WIDTH(PX_W), .DEPTH(LINES * MAX_SPANS)) u_end_ram (
        .aclk    (aclk),
        .wr_en   (sp_we),
        .wr_addr (sp_waddr),
        .wr_data (obuf_e[j_reg[SPAN_W-1:0]]),
        .rd_en   (sp_re),
        .rd_addr (en_raddr),
        .rd_data (en_rdata)
    );

    ssset_ram #(.WIDTH(CNT_W), .DEPTH(LINES)) u_count_ram (
        .aclk    (aclk),
        .wr_en   (cnt_we),
        .wr_addr (lidx),
        .wr_data (k_reg),
        .rd_en   (cnt_re),
        .rd_addr (lidx),
        .rd_data (cnt_rdata)
    );

    // ---------------------------------------------------------------
    // shared span evaluator
    // ---------------------------------------------------------------
    step_t step;

    ssset_eval u_eval (
        .mode   (mode_reg),
        .span_s (st_rdata),
        .span_e (en_rdata),
        .x1     (x1_reg),
        .x2     (x2_reg),
        .q_px   (xs_reg),
        .acc_s  (acc_s_reg),
        .acc_e  (acc_e_reg),
        .merged (merged_reg),
        .pend   (pend_reg),
        .step   (step)
    );

    // a span leaves the evaluator (or the pending union at the end)
    logic            em_valid, full_hit;
    logic [PX_W-1:0] em_s, em_e;
    logic [CNT_W-1:0] k_after;

    always_comb begin
        em_valid = 1'b0;
        em_s     = step.emit_s;
        em_e     = step.emit_e;
        if (state_reg == ST_EVAL) begin
            em_valid = step.emit;
        end else if (state_reg == ST_FINISH && mode_reg == MODE_ADD && !merged_reg) begin
            em_valid = 1'b1;
            em_s     = acc_s_reg;
            em_e     = acc_e_reg;
        end
    end

    assign full_hit = em_valid && (k_reg == CNT_W'(MAX_SPANS));
    assign k_after  = k_reg + CNT_W'(em_valid);

    // ---------------------------------------------------------------
    // sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CLIP;
                end
            end
            ST_CLIP: begin
                if (kind_reg == KIND_CLR) begin
                    state_next = ST_RESP;
                end else if (!line_ok) begin
                    state_next = ST_INFO_RD;
                end else begin
                    state_next = ST_CNT_RD;
                end
            end
            ST_CNT_RD: state_next = ST_CNT_WT;
            ST_CNT_WT: begin
                if (mode_reg == MODE_INFO) begin
                    state_next = ST_INFO_RD;
                end else if (n_eff == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_EVAL;
            ST_EVAL: begin
                if (full_hit) begin
                    state_next = ST_INFO_RD;
                end else if (step.adv) begin
                    state_next = (i_reg + CNT_W'(1) == n_reg) ? ST_FINISH : ST_FETCH;
                end
            end
            ST_FINISH: begin
                if (full_hit || mode_reg == MODE_QRY) begin
                    state_next = ST_INFO_RD;
                end else if (k_after == '0) begin
                    state_next = ST_CNT_WR;
                end else begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                if (j_reg + CNT_W'(1) == k_reg) begin
                    state_next = ST_CNT_WR;
                end
            end
            ST_CNT_WR: state_next = ST_INFO_RD;
            ST_INFO_RD: state_next = info_zero ? ST_RESP : ST_INFO_WT;
            ST_INFO_WT: state_next = ST_RESP;
            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer: memory controls
    // ---------------------------------------------------------------
    always_comb begin
        sp_re    = 1'b0;
        sp_we    = 1'b0;
        cnt_re   = 1'b0;
        cnt_we   = 1'b0;
        sp_waddr = {lidx, j_reg[SPAN_W-1:0]};
        st_raddr = {lidx, i_reg[SPAN_W-1:0]};
        en_raddr = {lidx, i_reg[SPAN_W-1:0]};
        unique case (state_reg)
            ST_CNT_RD: cnt_re = 1'b1;
            ST_FETCH:  sp_re  = 1'b1;
            ST_WB:     sp_we  = 1'b1;
            ST_CNT_WR: cnt_we = 1'b1;
            ST_INFO_RD: begin
                // first span start and last span end of the line
                sp_re    = !info_zero;
                st_raddr = {lidx, SPAN_W'(0)};
                en_raddr = {lidx, n_m1[SPAN_W-1:0]};
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
            first_line_reg <= '0;
            last_line_reg  <= MINLINE_W'(255);
            min_px_reg     <= '0;
            max_px_reg     <= PX_W'(1023);
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLIP && kind_reg == KIND_CLR) begin
                valid_reg <= '0;
            end else if (state_reg == ST_CNT_WR) begin
                valid_reg[lidx] <= 1'b1;
            end
            if (state_reg == ST_RESP && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_MIN_LINE: first_line_reg <= cfg_data[MINLINE_W-1:0];
                    REG_MAX_LINE: last_line_reg  <= cfg_data[MINLINE_W-1:0];
                    REG_MIN_PX:   min_px_reg     <= cfg_data[PX_W-1:0];
                    REG_MAX_PX:   max_px_reg     <= cfg_data[PX_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                kind_reg   <= kind_t'(s_tuser);
                xs_reg     <= s_tdata[11:0];
                xe_reg     <= s_tdata[23:12];
                line_reg   <= s_tdata[34:24];
                align_reg  <= s_tdata[35];
                hit_reg    <= 1'b0;
                i_reg      <= '0;
                k_reg      <= '0;
                j_reg      <= '0;
                merged_reg <= 1'b0;
                pend_reg   <= 1'b0;
            end
            ST_CLIP: begin
                x1_reg      <= lo_c[PX_W-1:0];
                x2_reg      <= hi_c[PX_W-1:0];
                acc_s_reg   <= lo_c[PX_W-1:0];
                acc_e_reg   <= hi_c[PX_W-1:0];
                line_ok_reg <= line_ok;
                n_reg       <= '0;
                left_reg    <= '0;
                right_reg   <= '0;
                status_reg  <= STAT_DONE;
                unique case (kind_reg)
                    KIND_ADD: mode_reg <= MODE_ADD;
                    KIND_DEL: mode_reg <= MODE_DEL;
                    default:  mode_reg <= MODE_QRY;
                endcase
                if (kind_reg != KIND_CLR) begin
                    if (!line_ok) begin
                        status_reg <= STAT_IGNORED;
                    end else if (kind_reg != KIND_QRY && (!win_ok || clip_empty)) begin
                        status_reg <= STAT_IGNORED;
                        mode_reg   <= MODE_INFO;
                    end
                end
            end
            ST_CNT_WT: n_reg <= n_eff;
            ST_EVAL, ST_FINISH: begin
                if (state_reg == ST_EVAL) begin
                    acc_s_reg  <= step.acc_s_next;
                    acc_e_reg  <= step.acc_e_next;
                    merged_reg <= step.merged_next;
                    pend_reg   <= step.pend_next;
                    hit_reg    <= hit_reg | step.hit;
                    if (step.adv) begin
                        i_reg <= i_reg + CNT_W'(1);
                    end
                end
                if (full_hit) begin
                    status_reg <= STAT_FULL;
                end else if (em_valid) begin
                    obuf_s[k_reg[SPAN_W-1:0]] <= em_s;
                    obuf_e[k_reg[SPAN_W-1:0]] <= em_e;
                    k_reg <= k_after;
                end
            end
            ST_WB:     j_reg <= j_reg + CNT_W'(1);
            ST_CNT_WR: n_reg <= k_reg;
            ST_INFO_WT: begin
                left_reg  <= st_rdata;
                right_reg <= en_rdata;
            end
            default: begin
            end
        endcase
        if (state_reg == ST_RESP && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {6'b0, right_reg, left_reg, n_reg, hit_reg};
            m_tuser_reg <= status_reg;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

`ifndef NO_ASSERTIONS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("command taken while busy");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CNT_WR) |-> (k_reg <= CNT_W'(MAX_SPANS)))
        else $error("line span count beyond capacity");

    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL) |-> (i_reg < n_reg))
        else $error("span walk past line count");

    a_wb_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WB) |-> (j_reg < k_reg))
        else $error("write-back past new span count");
`endif

endmodule

`default_nettype wire

FILE: dv/scanline_span_set_checker.sv
`timescale 1ns / 100ps
// scanline_span_set_checker: watches the command, result and window channels,
// keeps its own span store, predicts every result and compares; uses ssset_pkg
module scanline_span_set_checker
    import ssset_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [39:0]          s_tdata,
    input  wire logic [1:0]           s_tuser,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [31:0]          m_tdata,
    input  wire logic [1:0]           m_tuser,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output int                        fail_count,
    output int                        pending
);

    typedef struct packed {
        status_t         status;
        logic            hit;
        logic [4:0]      cnt;
        logic [PX_W-1:0] lo;
        logic [PX_W-1:0] hi;
    } line_result_t;

    logic [PX_W-1:0] span_lo [LINES][MAX_SPANS];
    logic [PX_W-1:0] span_hi [LINES][MAX_SPANS];
    int              span_cnt [LINES];
    int              win_line_lo, win_line_hi, win_px_lo, win_px_hi;
    line_result_t    expected_q [$];

    // line summary fields; zero for a line outside the store
    function automatic void summarize(input int l, inout line_result_t r);
        r.cnt = '0;
        r.lo  = '0;
        r.hi  = '0;
        if (l >= 0 && l < LINES && span_cnt[l] > 0) begin
            r.cnt = 5'(span_cnt[l]);
            r.lo  = span_lo[l][0];
            r.hi  = span_hi[l][span_cnt[l]-1];
        end
    endfunction

    function automatic line_result_t predict_word(input kind_t kind, input logic [39:0] d);
        line_result_t r;
        int x1, x2, l, t, s, e, n, i, k;
        int ns [MAX_SPANS+2];
        int ne [MAX_SPANS+2];
        x1 = int'($signed(d[11:0]));
        x2 = int'($signed(d[23:12]));
        l  = int'($signed(d[34:24]));
        r  = '0;
        r.status = STAT_DONE;
        if (kind == KIND_CLR) begin
            foreach (span_cnt[j]) span_cnt[j] = 0;
            return r;
        end
        if (kind == KIND_QRY) begin
            if (l < 0 || l >= LINES) r.status = STAT_IGNORED;
            else
                for (i = 0; i < span_cnt[l]; i++)
                    if (x1 >= int'(span_lo[l][i]) && x1 <= int'(span_hi[l][i])) r.hit = 1'b1;
            summarize(l, r);
            return r;
        end
        if (l < 0 || l >= LINES || l < win_line_lo || l > win_line_hi) begin
            r.status = STAT_IGNORED;
            summarize(l, r);
            return r;
        end
        if (x2 < x1) begin
            t = x1; x1 = x2; x2 = t;
        end
        // widen to 4-pixel blocks before clipping
        if (d[35]) begin
            x1 = x1 - (x1 & 3);
            x2 = x2 + 3 - (x2 & 3);
        end
        if (x1 < win_px_lo) x1 = win_px_lo;
        if (x2 > win_px_hi) x2 = win_px_hi;
        if (x2 > PIXELS - 1) x2 = PIXELS - 1;
        if (x1 > x2) begin
            r.status = STAT_IGNORED;
            summarize(l, r);
            return r;
        end
        n = span_cnt[l];
        k = 0;
        i = 0;
        if (kind == KIND_ADD) begin
            s = x1;
            e = x2;
            while (i < n && int'(span_hi[l][i]) + 1 < x1) begin
                ns[k] = span_lo[l][i]; ne[k] = span_hi[l][i]; k++; i++;
            end
            // absorb every span that overlaps or touches
            while (i < n && int'(span_lo[l][i]) <= x2 + 1) begin
                if (int'(span_lo[l][i]) < s) s = span_lo[l][i];
                if (int'(span_hi[l][i]) > e) e = span_hi[l][i];
                i++;
            end
            ns[k] = s; ne[k] = e; k++;
            while (i < n && k <= MAX_SPANS) begin
                ns[k] = span_lo[l][i]; ne[k] = span_hi[l][i]; k++; i++;
            end
        end else begin
            for (i = 0; i < n && k <= MAX_SPANS; i++) begin
                s = span_lo[l][i];
                e = span_hi[l][i];
                if (e < x1 || s > x2) begin
                    ns[k] = s; ne[k] = e; k++;
                end else begin
                    if (s < x1) begin
                        ns[k] = s; ne[k] = x1 - 1; k++;
                    end
                    if (e > x2 && k <= MAX_SPANS) begin
                        ns[k] = x2 + 1; ne[k] = e; k++;
                    end
                end
            end
            if (i < n) k = MAX_SPANS + 1;
        end
        if (k > MAX_SPANS) begin
            r.status = STAT_FULL;
            summarize(l, r);
            return r;
        end
        for (i = 0; i < k; i++) begin
            span_lo[l][i] = PX_W'(ns[i]);
            span_hi[l][i] = PX_W'(ne[i]);
        end
        span_cnt[l] = k;
        summarize(l, r);
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge aclk) begin
        line_result_t got, want;
        if (!aresetn) begin
            foreach (span_cnt[j]) span_cnt[j] = 0;
            win_line_lo = 0;
            win_line_hi = 255;
            win_px_lo   = 0;
            win_px_hi   = 1023;
            expected_q.delete();
            fail_count  = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MIN_LINE: win_line_lo = int'(cfg_data[MINLINE_W-1:0]);
                    REG_MAX_LINE: win_line_hi = int'(cfg_data[MINLINE_W-1:0]);
                    REG_MIN_PX:   win_px_lo   = int'(cfg_data);
                    REG_MAX_PX:   win_px_hi   = int'(cfg_data);
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.status = status_t'(m_tuser);
                got.hit    = m_tdata[0];
                got.cnt    = m_tdata[5:1];
                got.lo     = m_tdata[15:6];
                got.hi     = m_tdata[25:16];
                if (expected_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result word status=%0d hit=%0d cnt=%0d lo=%0d hi=%0d",
                             $time, got.status, got.hit, got.cnt, got.lo, got.hi);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want || m_tdata[31:26] !== '0) begin
                        fail_count++;
                        $display("%0t: mismatch expected status=%0d hit=%0d cnt=%0d lo=%0d hi=%0d",
                                 $time, want.status, want.hit, want.cnt, want.lo, want.hi);
                        $display("%0t:          actual   status=%0d hit=%0d cnt=%0d lo=%0d hi=%0d pad=%0h",
                                 $time, got.status, got.hit, got.cnt, got.lo, got.hi,
                                 m_tdata[31:26]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(predict_word(kind_t'(s_tuser), s_tdata));
        end
    end

endmodule

FILE: dv/scanline_span_set_top_test.sv
`timescale 1ns / 100ps
// scanline_span_set_top_test: drives commands and window writes into the span
// set and gives the verdict; depends on ssset_pkg, the block and the checker
module scanline_span_set_top_test;
    import ssset_pkg::*;

    localparam int CYCLE_LIMIT = 900000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [39:0]          s_tdata;   // x_start, x_end, line, align, zero pad
    logic [1:0]           s_tuser;   // kind
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;   // hit, span total, first px, last px, pad
    logic [1:0]           m_tuser;   // status
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending;
    int                   cycles;
    bit                   idling_on;   // random gaps on both sides
    bit                   rx_long;     // ask the receiver for a long hold-off

    scanline_span_set_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    scanline_span_set_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog: a hung handshake ends the run
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // result side: ready with random stall bursts, plus one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_long) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                rx_long = 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                // the loop edge adds the last cycle of the burst
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // offer one command word and hold it until taken; an idle burst may come first
    task automatic send_word(input kind_t kind, input int xs, input int xe, input int ln,
                             input bit al);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, al, ln[10:0], xe[11:0], xs[11:0]};
        do @(posedge aclk); while (!s_tready);
    endtask

    // window registers change only with nothing in flight
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_window(input int line_lo, input int line_hi, input int px_lo,
                                input int px_hi);
        logic [CFG_IDX_W-1:0] idx [4];
        int                   val [4];
        drain();
        idx = '{REG_MIN_LINE, REG_MAX_LINE, REG_MIN_PX, REG_MAX_PX};
        val = '{line_lo, line_hi, px_lo, px_hi};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= CFG_W'(val[i]);
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly clustered intervals on a few lines so spans pile up, some wild words
    task automatic random_words(input int count);
        int    pick, xs, xe, ln;
        kind_t kind;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      kind = KIND_ADD;
            else if (pick < 75) kind = KIND_DEL;
            else if (pick < 99) kind = KIND_QRY;
            else                kind = KIND_CLR;
            if ($urandom_range(0, 9) == 0) begin
                xs = $urandom;
                xe = $urandom;
                ln = $urandom;
            end else begin
                xs = $urandom_range(0, 140);
                xe = xs + $urandom_range(0, 5);
                if ($urandom_range(0, 3) == 0) xe = xs - $urandom_range(0, 5);
                ln = $urandom_range(0, 3);
            end
            send_word(kind, xs, xe, ln, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        idling_on = 1'b1;
        rx_long   = 1'b0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= KIND_ADD;
        cfg_valid <= 1'b0;
        cfg_index <= REG_MIN_LINE;
        cfg_data  <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, every kind, swap, align, clip, out-of-range lines
        send_word(KIND_ADD, -2048, 2047, 0, 1'b0);
        send_word(KIND_QRY, 1023, 0, 0, 1'b0);
        send_word(KIND_DEL, 2047, -2048, 0, 1'b1);
        send_word(KIND_ADD, 9, 5, 1, 1'b1);
        send_word(KIND_ADD, 13, 13, 1, 1'b0);
        send_word(KIND_QRY, 12, 0, 1, 1'b0);
        send_word(KIND_ADD, 1500, 1200, 1, 1'b0);
        send_word(KIND_ADD, 5, 5, -1024, 1'b0);
        send_word(KIND_QRY, 5, 5, 1023, 1'b1);
        send_word(KIND_DEL, 5, 5, 256, 1'b0);
        send_word(KIND_DEL, 7, 7, 1, 1'b0);
        // fill one line to capacity, then overflow by add and by split
        for (int i = 0; i < 17; i++)
            send_word(KIND_ADD, 10 * i, 10 * i + 2, 5, 1'b0);
        send_word(KIND_DEL, 11, 11, 5, 1'b0);
        send_word(KIND_QRY, 161, 0, 5, 1'b0);
        send_word(KIND_CLR, 0, 0, 0, 1'b0);
        send_word(KIND_QRY, 20, 0, 5, 1'b0);

        // sender keeps offering while the receiver holds off, so the block backs up
        rx_long = 1'b1;
        random_words(20);
        random_words(230);

        write_window(2, 200, 10, 900);
        random_words(200);
        write_window(10, 5, 600, 500);
        random_words(60);
        write_window(3, 3, 1023, 1023);
        random_words(60);
        write_window(0, 255, 0, 1023);
        random_words(300);
        write_window(1, 2, 0, 511);
        idling_on = 1'b0;
        random_words(300);

        drain();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
